>>> sv/cassette_block_deframer_top_defines.svh
// Assertion macros shared by the cassette block deframer RTL.
// No dependencies; included by files that carry assertions.
`ifndef CASSETTE_BLOCK_DEFRAMER_TOP_DEFINES_SVH
`define CASSETTE_BLOCK_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CBD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbd assertion failed");

// next-cycle implication, disabled during reset
`define CBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbd assertion failed");

`endif

>>> sv/cbd_pkg.sv
// Package for the cassette block deframer: byte codes, phase and result types.
// No dependencies.
package cbd_pkg;

  localparam int COUNT_W = 17;

  localparam logic [7:0] SYNC_BYTE = 8'h16;
  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] ETB_BYTE  = 8'h17;
  localparam int         HIGH_BIT  = 7;

  typedef enum logic [3:0] {
    PH_SYNC,
    PH_START,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_NAME1,
    PH_NAME2,
    PH_DATA,
    PH_ETB,
    PH_SUM
  } phase_t;

  typedef enum logic {
    KIND_DATA,
    KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_TRAILER,
    ST_BAD_SUM
  } status_t;

  typedef struct packed {
    kind_t                result_kind;
    logic [7:0]           out_byte;
    logic [15:0]          block_label;
    logic [COUNT_W-1:0]   byte_count;
    logic                 is_object;
    status_t              status;
  } result_t;

endpackage

>>> sv/cbd_out_buf.sv
// Two-entry output buffer (result register plus skid register).
// Depends on cbd_pkg and cassette_block_deframer_top_defines.svh.
`include "cassette_block_deframer_top_defines.svh"

module cbd_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cbd_pkg::result_t push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output cbd_pkg::result_t out_data
);

  logic             skid_valid;
  cbd_pkg::result_t skid_data;
  logic             pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && out_valid && !pop) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end

  `CBD_ASSERT_IMPL(a_skid_implies_out, skid_valid, out_valid)
  `CBD_ASSERT_IMPL(a_no_push_when_full, push, !skid_valid)
  `CBD_ASSERT_NEXT(a_held_result, out_valid && out_stall, out_valid)

endmodule

>>> sv/cassette_block_deframer_top.sv
// Each result item is registered in the output buffer when the input item that causes it is accepted.
// Throughput: one input item per cycle while in_stall is low; the per-byte phase update is a single step.
// A two-entry output buffer keeps input flowing while one result waits.
// Input stalls only while both output entries are full.
// Reset (rst, synchronous): sync hunt, counts, checksum and type flag cleared,
// output buffer emptied; the block label is left unset until a header writes it.
`include "cassette_block_deframer_top_defines.svh"

module cassette_block_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] block_label,
  output logic [16:0] byte_count,
  output logic        is_object,
  output logic [1:0]  status
);

  cbd_pkg::phase_t                 phase, phase_next;
  logic [cbd_pkg::COUNT_W-1:0]     expected_count, expected_count_next;
  logic [cbd_pkg::COUNT_W-1:0]     received_count, received_count_next;
  logic [7:0]                      running_sum, running_sum_next;
  logic [15:0]                     label_store, label_store_next;
  logic                            object_flag, object_flag_next;

  logic             accept;
  logic             push;
  logic             buf_full;
  cbd_pkg::result_t res;
  cbd_pkg::result_t out_res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= cbd_pkg::PH_SYNC;
      expected_count <= '0;
      received_count <= '0;
      running_sum    <= '0;
      object_flag    <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      expected_count <= expected_count_next;
      received_count <= received_count_next;
      running_sum    <= running_sum_next;
      object_flag    <= object_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      label_store <= label_store_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    expected_count_next = expected_count;
    received_count_next = received_count;
    running_sum_next    = running_sum;
    label_store_next    = label_store;
    object_flag_next    = object_flag;
    push                = 1'b0;
    res.result_kind     = cbd_pkg::KIND_END;
    res.out_byte        = 8'h00;
    res.block_label     = label_store;
    res.byte_count      = received_count;
    res.is_object       = object_flag;
    res.status          = cbd_pkg::ST_OK;

    unique case (phase)
      cbd_pkg::PH_START: begin
        if (in_byte == cbd_pkg::ESC_BYTE) begin
          phase_next = cbd_pkg::PH_LEN_HI;
        end else if (in_byte != cbd_pkg::SYNC_BYTE) begin
          phase_next = cbd_pkg::PH_SYNC;
        end
      end
      cbd_pkg::PH_LEN_HI: begin
        expected_count_next = {1'b0, in_byte, 8'h00};
        phase_next          = cbd_pkg::PH_LEN_LO;
      end
      cbd_pkg::PH_LEN_LO: begin
        expected_count_next = {1'b0, expected_count[15:8], in_byte} + 17'd1;
        phase_next          = cbd_pkg::PH_NAME1;
      end
      cbd_pkg::PH_NAME1: begin
        label_store_next = {in_byte, label_store[7:0]};
        phase_next       = cbd_pkg::PH_NAME2;
      end
      cbd_pkg::PH_NAME2: begin
        label_store_next = {label_store[15:8], in_byte};
        phase_next       = cbd_pkg::PH_DATA;
      end
      cbd_pkg::PH_DATA: begin
        received_count_next = received_count + 17'd1;
        running_sum_next    = running_sum + in_byte;
        object_flag_next    = object_flag | in_byte[cbd_pkg::HIGH_BIT];
        if (received_count_next == expected_count) begin
          phase_next = cbd_pkg::PH_ETB;
        end
        push            = 1'b1;
        res.result_kind = cbd_pkg::KIND_DATA;
        res.out_byte    = in_byte;
        res.byte_count  = received_count_next;
        res.is_object   = object_flag_next;
      end
      cbd_pkg::PH_ETB: begin
        if (in_byte == cbd_pkg::ETB_BYTE) begin
          phase_next = cbd_pkg::PH_SUM;
        end else begin
          push                = 1'b1;
          res.status          = cbd_pkg::ST_BAD_TRAILER;
          phase_next          = cbd_pkg::PH_SYNC;
          expected_count_next = '0;
          received_count_next = '0;
          running_sum_next    = '0;
          object_flag_next    = 1'b0;
        end
      end
      cbd_pkg::PH_SUM: begin
        push                = 1'b1;
        res.status          = (in_byte == running_sum) ? cbd_pkg::ST_OK : cbd_pkg::ST_BAD_SUM;
        phase_next          = cbd_pkg::PH_SYNC;
        expected_count_next = '0;
        received_count_next = '0;
        running_sum_next    = '0;
        object_flag_next    = 1'b0;
      end
      default: begin
        phase_next = (in_byte == cbd_pkg::SYNC_BYTE) ? cbd_pkg::PH_START : cbd_pkg::PH_SYNC;
      end
    endcase
  end

  cbd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign result_kind = out_res.result_kind;
  assign out_byte    = out_res.out_byte;
  assign block_label = out_res.block_label;
  assign byte_count  = out_res.byte_count;
  assign is_object   = out_res.is_object;
  assign status      = out_res.status;

  `CBD_ASSERT_IMPL(a_data_count_below_len, phase == cbd_pkg::PH_DATA,
                   received_count < expected_count)
  `CBD_ASSERT_IMPL(a_data_status_ok, out_valid && result_kind == cbd_pkg::KIND_DATA,
                   status == cbd_pkg::ST_OK)
  `CBD_ASSERT_IMPL(a_report_byte_zero, out_valid && result_kind == cbd_pkg::KIND_END,
                   out_byte == 8'h00)

endmodule
